FILE: src/upe_pkg.sv
// ============================================================================
// upe_pkg - shared types, constants and functions of the URL percent encoder
// Holds the byte classification, hex digit lookup and the queue entry type.
// ============================================================================
package upe_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Unreserved bytes, one bit per byte code, byte 0 in bit 0
    localparam logic [255:0] UNRESERVED_MAP = {
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h07FF_FFFE, 32'h87FF_FFFE, 32'h03FF_6382, 32'h0000_0000
    };

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_SLASH = 2'd2;

    // One queued operation: a byte to pass or to escape
    typedef struct packed {
        logic [7:0] data;
        logic       esc;
        logic       last;
    } upe_op_t;

    typedef struct packed {
        logic pass;
        logic set_query;
    } upe_cls_t;

    typedef enum logic {
        FE_TAKE,
        FE_FLUSH
    } fe_state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_HIGH,
        PH_LOW
    } ph_t;

    function automatic logic upe_is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [7:0] upe_hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

    function automatic upe_cls_t upe_classify(
        input logic [7:0] c,
        input logic       ahead,
        input logic [7:0] a1,
        input logic [7:0] a2,
        input logic       path,
        input logic       qseen
    );
        upe_cls_t r;
        r.pass      = 1'b0;
        r.set_query = 1'b0;
        if (UNRESERVED_MAP[c]) begin
            r.pass = 1'b1;
        end else if (path && (c == CH_SLASH)) begin
            r.pass = 1'b1;
        end else if (path && ahead && (c == CH_PERCENT) &&
                     upe_is_hex(a1) && upe_is_hex(a2)) begin
            r.pass = 1'b1;
        end else if ((c == CH_QUEST) && !qseen) begin
            r.pass      = 1'b1;
            r.set_query = 1'b1;
        end else if (((c == CH_AMP) || (c == CH_EQUAL)) && qseen) begin
            r.pass = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: src/upe_queue.sv
// ============================================================================
// upe_queue - operation queue between classifier and expander
// Small register queue; push and pop may happen in the same cycle.
// ============================================================================
module upe_queue #(
    parameter int DEPTH = upe_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  upe_pkg::upe_op_t  push_op,
    output logic              pop_valid,
    input  logic              pop_ready,
    output upe_pkg::upe_op_t  pop_op
);
    import upe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upe_op_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy exceeds depth");

endmodule

FILE: src/upe_front.sv
// ============================================================================
// upe_front - input side of the URL percent encoder
// Hold the two-byte lookahead, judge each byte and queue pass/escape ops.
// ============================================================================
module upe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_char,
    input  logic              in_present,
    input  logic              in_last,
    input  logic [1:0]        in_mode,
    output logic              push_valid,
    input  logic              push_ready,
    output upe_pkg::upe_op_t  push_op
);
    import upe_pkg::*;

    fe_state_t  state_reg, state_next;
    logic [7:0] win0_reg, win0_next;
    logic [7:0] win1_reg, win1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       query_reg, query_next;
    logic [7:0] buf0_reg, buf0_next;
    logic [7:0] buf1_reg, buf1_next;
    logic [7:0] buf2_reg, buf2_next;
    logic [1:0] fcnt_reg, fcnt_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] fmode_reg, fmode_next;

    logic       accept;
    logic       byte_avail;
    logic       last_byte;
    logic       slash;
    logic       flush_done;
    logic [7:0] sel_char;
    logic       sel_ahead;
    logic [7:0] sel_a1, sel_a2;
    logic       sel_path;
    upe_cls_t   cls;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FE_TAKE: begin
                if (accept && in_last) begin
                    state_next = FE_FLUSH;
                end
            end
            FE_FLUSH: begin
                if (flush_done) begin
                    state_next = FE_TAKE;
                end
            end
            default: state_next = FE_TAKE;
        endcase
    end

    // Outputs and classification
    always_comb begin
        in_ready   = 1'b0;
        byte_avail = (k_reg < fcnt_reg);
        last_byte  = (k_reg == (fcnt_reg - 2'd1));
        slash      = (fmode_reg == MODE_SLASH);
        sel_char   = win0_reg;
        sel_ahead  = 1'b1;
        sel_a1     = win1_reg;
        sel_a2     = in_char;
        sel_path   = (in_mode != MODE_PLAIN);
        push_valid = 1'b0;
        flush_done = 1'b0;
        case (state_reg)
            FE_TAKE: begin
                in_ready   = push_ready;
                push_valid = in_valid && in_present && !in_last && (cnt_reg == 2'd2);
            end
            FE_FLUSH: begin
                case (k_reg)
                    2'd0:    sel_char = buf0_reg;
                    2'd1:    sel_char = buf1_reg;
                    default: sel_char = buf2_reg;
                endcase
                sel_ahead  = (k_reg == 2'd0) && (fcnt_reg == 2'd3);
                sel_a1     = buf1_reg;
                sel_a2     = buf2_reg;
                sel_path   = (fmode_reg != MODE_PLAIN);
                push_valid = byte_avail || slash;
                if (byte_avail) begin
                    flush_done = push_ready && last_byte && !slash;
                end else begin
                    flush_done = !slash || push_ready;
                end
            end
            default: ;
        endcase
        cls = upe_classify(sel_char, sel_ahead, sel_a1, sel_a2, sel_path, query_reg);
        if ((state_reg == FE_FLUSH) && !byte_avail) begin
            push_op.data = CH_SLASH;
            push_op.esc  = 1'b0;
            push_op.last = 1'b1;
        end else begin
            push_op.data = sel_char;
            push_op.esc  = !cls.pass;
            push_op.last = (state_reg == FE_FLUSH) && last_byte && !slash;
        end
    end

    assign accept = in_valid && in_ready;

    // Register next values
    always_comb begin
        win0_next  = win0_reg;
        win1_next  = win1_reg;
        cnt_next   = cnt_reg;
        query_next = query_reg;
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        buf2_next  = buf2_reg;
        fcnt_next  = fcnt_reg;
        k_next     = k_reg;
        fmode_next = fmode_reg;
        if (accept && in_last) begin
            buf0_next  = win0_reg;
            buf1_next  = win1_reg;
            buf2_next  = 8'h00;
            if (in_present) begin
                case (cnt_reg)
                    2'd0:    buf0_next = in_char;
                    2'd1:    buf1_next = in_char;
                    default: buf2_next = in_char;
                endcase
            end
            fcnt_next  = cnt_reg + {1'b0, in_present};
            k_next     = 2'd0;
            fmode_next = in_mode;
            cnt_next   = 2'd0;
        end else if (accept && in_present) begin
            if (cnt_reg == 2'd2) begin
                // window full: oldest byte was queued, shift in the new one
                win0_next = win1_reg;
                win1_next = in_char;
                if (cls.set_query) begin
                    query_next = 1'b1;
                end
            end else begin
                if (cnt_reg == 2'd0) begin
                    win0_next = in_char;
                end else begin
                    win1_next = in_char;
                end
                cnt_next = cnt_reg + 2'd1;
            end
        end
        if ((state_reg == FE_FLUSH) && byte_avail && push_ready) begin
            k_next = k_reg + 2'd1;
            if (cls.set_query) begin
                query_next = 1'b1;
            end
        end
        if (flush_done) begin
            query_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_TAKE;
            cnt_reg   <= 2'd0;
            query_reg <= 1'b0;
            fcnt_reg  <= 2'd0;
            k_reg     <= 2'd0;
            fmode_reg <= MODE_PLAIN;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            query_reg <= query_next;
            fcnt_reg  <= fcnt_next;
            k_reg     <= k_next;
            fmode_reg <= fmode_next;
        end
    end

    always_ff @(posedge aclk) begin
        win0_reg <= win0_next;
        win1_reg <= win1_next;
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
        buf2_reg <= buf2_next;
    end

    a_window_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("lookahead count beyond two");

    a_flush_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FE_FLUSH) |-> (k_reg <= fcnt_reg))
        else $error("flush index ran past held bytes");

endmodule

FILE: src/upe_back.sv
// ============================================================================
// upe_back - output side of the URL percent encoder
// Expand queued ops into output bytes: one byte, or '%' and two hex digits.
// ============================================================================
module upe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  upe_pkg::upe_op_t  pop_op,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              out_last
);
    import upe_pkg::*;

    ph_t        phase_reg, phase_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    logic       load;
    logic       take;
    logic       final_byte;
    logic [7:0] emit_char;

    // Outputs of the expander
    always_comb begin
        load       = !m_tvalid_reg || out_ready;
        take       = load && pop_valid;
        emit_char  = pop_op.data;
        final_byte = 1'b1;
        case (phase_reg)
            PH_FIRST: begin
                emit_char  = pop_op.esc ? CH_PERCENT : pop_op.data;
                final_byte = !pop_op.esc;
            end
            PH_HIGH: begin
                emit_char  = upe_hex_digit(pop_op.data[7:4]);
                final_byte = 1'b0;
            end
            PH_LOW: begin
                emit_char  = upe_hex_digit(pop_op.data[3:0]);
                final_byte = 1'b1;
            end
            default: ;
        endcase
        pop_ready = take && final_byte;
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            case (phase_reg)
                PH_FIRST: phase_next = final_byte ? PH_FIRST : PH_HIGH;
                PH_HIGH:  phase_next = PH_LOW;
                PH_LOW:   phase_next = PH_FIRST;
                default:  phase_next = PH_FIRST;
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (take) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit_char;
            m_tlast_next  = pop_op.last && final_byte;
        end else if (out_ready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign out_valid = m_tvalid_reg;
    assign out_char  = m_tdata_reg;
    assign out_last  = m_tlast_reg;

    a_escape_holds_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_FIRST) |-> pop_valid)
        else $error("escape in progress without an op at queue head");

    a_escape_has_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_FIRST) |-> m_tvalid_reg)
        else $error("escape in progress with empty output register");

endmodule

FILE: src/url_percent_encoder_core.sv
// ============================================================================
// url_percent_encoder_core - streaming URL percent encoder
// Encode a URL one byte per input item into its percent-encoded form.
// ============================================================================
//
//  Channel  | Ports  | Payload
//  ---------+--------+----------------------------------------------------
//  input    | s_*    | tdata: char_in; tuser: char_present, path_mode;
//           |        | tlast: end_of_string
//  output   | m_*    | tdata: char_out; tlast: last_out
//
//  Flow: an item that is not the last of a string is taken while the op
//  queue has room, so such items go back to back. Each escaped byte is
//  expanded into three output bytes, and the expander sends one byte per
//  cycle while the receiver takes them, so escaped bytes lower the rate.
//  After the last item of a string is taken, the input stays blocked until
//  the front has queued the ops it still holds (held bytes, the item's own
//  byte and, in slash mode, the trailing slash, at most four ops), while the
//  front drains the lookahead window.
//  Reset: aresetn, synchronous, active low; clears window, query flag, queue
//  and output valid. No clearing pass.
//  Stalls: m_tready low holds the output register; the queue lets the front
//  keep taking items until it fills.
//
module url_percent_encoder_core #(
    parameter int QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic [2:0] s_tuser,   // [0] char_present, [2:1] path_mode
    input  logic       s_tlast,   // end_of_string
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast    // last_out
);
    import upe_pkg::*;

    logic    push_valid, push_ready;
    upe_op_t push_op;
    logic    pop_valid, pop_ready;
    upe_op_t pop_op;

    // Front: hold lookahead, judge bytes, queue pass or escape ops
    upe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_present (s_tuser[0]),
        .in_last    (s_tlast),
        .in_mode    (s_tuser[2:1]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    // Queue: decouple classification from expansion
    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Back: expand each op into one or three output bytes
    upe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

FILE: tb/sv/url_percent_encoder_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// url_percent_encoder_checker - scoreboard for the URL percent encoder
// Watch both channels, predict the encoded bytes of every accepted input
// item and compare each accepted output item against the oldest prediction.
// ============================================================================
module url_percent_encoder_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic [2:0] s_tuser,   // [0] char_present, [2:1] path_mode
    input  logic       s_tlast,   // end_of_string
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] char_out
    input  logic       m_tlast,   // last_out
    output int         mismatch_count,
    output int         pending_results
);

    // Bytes that always pass unchanged, byte code n in bit n
    localparam logic [255:0] PASS_SET = {
        128'h0, 32'h07FF_FFFE, 32'h87FF_FFFE, 32'h03FF_6382, 32'h0000_0000
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } enc_byte_t;

    enc_byte_t  encoded_bytes [$];
    logic [7:0] window [0:1];
    int         window_fill;
    logic       query_open;
    int         errors;

    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};       // '0'..'9'
        return 8'h41 + {4'h0, n} - 8'd10;   // 'A'..'F'
    endfunction

    task automatic emit(input logic [7:0] ch);
        enc_byte_t e;
        e.ch   = ch;
        e.last = 1'b0;
        encoded_bytes.push_back(e);
    endtask

    task automatic encode_char(input logic [7:0] c, input logic ahead,
                               input logic [7:0] a1, input logic [7:0] a2,
                               input logic [1:0] mode);
        logic path;
        logic keep;
        path = (mode != upe_pkg::MODE_PLAIN);
        keep = 1'b0;
        if (PASS_SET[c]) begin
            keep = 1'b1;
        end else if (path && c == upe_pkg::CH_SLASH) begin
            keep = 1'b1;
        end else if (path && ahead && c == upe_pkg::CH_PERCENT &&
                     is_hex_char(a1) && is_hex_char(a2)) begin
            // already escaped, leave it alone
            keep = 1'b1;
        end else if (c == upe_pkg::CH_QUEST && !query_open) begin
            query_open = 1'b1;
            keep       = 1'b1;
        end else if ((c == upe_pkg::CH_AMP || c == upe_pkg::CH_EQUAL) && query_open) begin
            keep = 1'b1;
        end
        if (keep) begin
            emit(c);
        end else begin
            emit(upe_pkg::CH_PERCENT);
            emit(hex_char(c[7:4]));
            emit(hex_char(c[3:0]));
        end
    endtask

    task automatic clear_window();
        window[0]   = 8'h00;
        window[1]   = 8'h00;
        window_fill = 0;
        query_open  = 1'b0;
    endtask

    task automatic predict_item(input logic [7:0] c, input logic present,
                                input logic last, input logic [1:0] mode);
        logic [7:0] held [0:2];
        int         fill;
        int         base;
        logic       ahead;
        enc_byte_t  tail;
        if (!last) begin
            if (present) begin
                if (window_fill == 2) begin
                    encode_char(window[0], 1'b1, window[1], c, mode);
                    window[0] = window[1];
                    window[1] = c;
                end else begin
                    window[window_fill] = c;
                    window_fill++;
                end
            end
        end else begin
            // flush the window, then the new byte if present, then the slash in slash mode
            held[0] = window[0];
            held[1] = window[1];
            held[2] = 8'h00;
            fill    = window_fill;
            base    = encoded_bytes.size();
            if (present) begin
                held[fill] = c;
                fill++;
            end
            for (int k = 0; k < fill; k++) begin
                ahead = (k + 2 < fill);
                encode_char(held[k], ahead, ahead ? held[k+1] : 8'h00,
                            ahead ? held[k+2] : 8'h00, mode);
            end
            if (mode == upe_pkg::MODE_SLASH)
                emit(upe_pkg::CH_SLASH);
            if (encoded_bytes.size() > base) begin
                tail      = encoded_bytes.pop_back();
                tail.last = 1'b1;
                encoded_bytes.push_back(tail);
            end
            clear_window();
        end
    endtask

    initial begin
        errors = 0;
        clear_window();
    end

    always @(posedge aclk) begin
        enc_byte_t want;
        if (!aresetn) begin
            clear_window();
            encoded_bytes.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tuser[0], s_tlast, s_tuser[2:1]);
            if (m_tvalid && m_tready) begin
                if (encoded_bytes.size() == 0) begin
                    $error("unexpected item: char_out=%h last_out=%b", m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = encoded_bytes.pop_front();
                    if (m_tdata !== want.ch) begin
                        $error("char_out mismatch: expected %h, actual %h", want.ch, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_out mismatch: expected %b, actual %b",
                               want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
        mismatch_count  <= errors;
        pending_results <= encoded_bytes.size();
    end

endmodule

FILE: tb/sv/url_percent_encoder_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// url_percent_encoder_core_test - testbench top for the URL percent encoder
// Drive directed and random URL strings in bursts against a stalling
// receiver; the checker beside the block predicts and compares the output.
// ============================================================================
module url_percent_encoder_core_test;

    localparam int IDLE_LIMIT   = 1000;  // cycles without any handshake
    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int RANDOM_ITEMS = 136;
    localparam int DRAIN_CYCLES = 20;

    // path modes the package does not name
    localparam logic [1:0] MODE_PATH  = 2'd1;
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    // receiver stall styles
    localparam int RX_FREE = 0;
    localparam int RX_HALF = 1;
    localparam int RX_SLOW = 2;
    localparam int RX_BUSY = 3;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic [2:0] s_tuser  = 3'b000;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tlast;

    int         mismatch_count;
    int         pending_results;

    bit         hold_request = 1'b0;
    bit         hold_taken   = 1'b0;
    int         hold_left    = 0;
    int         rx_style     = RX_FREE;
    int         rx_phase     = 0;
    int         burst_left   = 0;
    bit         steady_send  = 1'b0;
    int         items_sent   = 0;
    int         idle_cycles  = 0;
    int         target;
    logic [7:0] url_bytes [$];

    always #4 aclk = ~aclk;

    url_percent_encoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    url_percent_encoder_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Receiver: change stall style at random intervals; once asked,
    // hold off completely so the encoder's queue fills and backs up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            if (rx_phase == 0) begin
                rx_style <= $urandom_range(RX_BUSY, RX_FREE);
                rx_phase <= $urandom_range(96, 16);
            end else begin
                rx_phase <= rx_phase - 1;
            end
            case (rx_style)
                RX_FREE: m_tready <= 1'b1;
                RX_HALF: m_tready <= 1'($urandom_range(1, 0));
                RX_SLOW: m_tready <= ($urandom_range(3, 0) == 0);
                default: m_tready <= ($urandom_range(7, 0) != 0);
            endcase
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item and hold it until accepted. Once a burst is used up, open a
    // new one, with a random gap in front of it unless the sender is kept steady.
    task automatic send_item(input logic [7:0] ch, input bit present,
                             input bit last, input logic [1:0] mode);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap        = steady_send ? 0 : $urandom_range(6, 0);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= {mode, present};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (present || last)
            items_sent++;
    endtask

    // Stop offering until every predicted byte has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_hex();
        case ($urandom_range(2, 0))
            0:       return 8'(8'h30 + $urandom_range(9, 0));   // digit
            1:       return 8'(8'h41 + $urandom_range(5, 0));   // upper A-F
            default: return 8'(8'h61 + $urandom_range(5, 0));   // lower a-f
        endcase
    endfunction

    // Build a string of mostly meaningful URL pieces: plain text, escapes
    // (some broken), slashes, query separators and arbitrary bytes.
    task automatic build_url(input int len);
        int sel;
        for (int i = 0; i < len; i++) begin
            sel = $urandom_range(99, 0);
            if (sel < 35) begin
                url_bytes.push_back(8'(8'h61 + $urandom_range(25, 0)));
            end else if (sel < 50) begin
                url_bytes.push_back(upe_pkg::CH_PERCENT);
                url_bytes.push_back(random_hex());
                if ($urandom_range(3, 0) == 0)
                    url_bytes.push_back(8'($urandom_range(255, 0)));
                else
                    url_bytes.push_back(random_hex());
            end else if (sel < 60) begin
                url_bytes.push_back(upe_pkg::CH_SLASH);
            end else if (sel < 70) begin
                case ($urandom_range(2, 0))
                    0:       url_bytes.push_back(upe_pkg::CH_QUEST);
                    1:       url_bytes.push_back(upe_pkg::CH_AMP);
                    default: url_bytes.push_back(upe_pkg::CH_EQUAL);
                endcase
            end else begin
                url_bytes.push_back(8'($urandom_range(255, 0)));
            end
        end
    endtask

    // Send the built string; optionally end it with an empty last item,
    // scatter skipped items in it, or change the mode from item to item.
    task automatic send_url(input logic [1:0] mode, input bit empty_end, input bit mixed);
        logic [1:0] item_mode;
        for (int i = 0; i < url_bytes.size(); i++) begin
            item_mode = mixed ? 2'($urandom_range(3, 0)) : mode;
            if ($urandom_range(19, 0) == 0)
                send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, item_mode);
            send_item(url_bytes[i], 1'b1, !empty_end && (i == url_bytes.size() - 1),
                      item_mode);
        end
        if (empty_end || url_bytes.size() == 0)
            send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, mode);
        url_bytes.delete();
    endtask

    task automatic random_urls(input int until_count);
        while (items_sent < until_count) begin
            build_url($urandom_range(10, 0));
            send_url(2'($urandom_range(3, 0)), $urandom_range(3, 0) == 0,
                     $urandom_range(4, 0) == 0);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // plain: control byte, first query mark passes, second is escaped,
        // separators pass once the query is open, top byte value
        send_item(8'h00,               1'b1, 1'b0, upe_pkg::MODE_PLAIN);
        send_item(upe_pkg::CH_QUEST,   1'b1, 1'b0, upe_pkg::MODE_PLAIN);
        send_item(upe_pkg::CH_QUEST,   1'b1, 1'b0, upe_pkg::MODE_PLAIN);
        send_item(upe_pkg::CH_AMP,     1'b1, 1'b0, upe_pkg::MODE_PLAIN);
        send_item(8'hFF,               1'b1, 1'b1, upe_pkg::MODE_PLAIN);
        // path rules: a formed escape passes, slash passes, a percent with
        // only one byte behind it at the end of the string is escaped
        send_item(upe_pkg::CH_PERCENT, 1'b1, 1'b0, MODE_PATH);
        send_item(8'h34,               1'b1, 1'b0, MODE_PATH);
        send_item(8'h61,               1'b1, 1'b0, MODE_PATH);
        send_item(upe_pkg::CH_SLASH,   1'b1, 1'b0, MODE_PATH);
        send_item(upe_pkg::CH_PERCENT, 1'b1, 1'b0, MODE_PATH);
        send_item(8'h34,               1'b1, 1'b1, MODE_PATH);
        // trailing slash: separators escaped outside a query, a skipped
        // item, then an empty last item that flushes the window
        send_item(upe_pkg::CH_AMP,     1'b1, 1'b0, upe_pkg::MODE_SLASH);
        send_item(upe_pkg::CH_EQUAL,   1'b1, 1'b0, upe_pkg::MODE_SLASH);
        send_item(8'hA5,               1'b0, 1'b0, upe_pkg::MODE_SLASH);
        send_item(8'h5A,               1'b1, 1'b0, upe_pkg::MODE_SLASH);
        send_item(8'hC3,               1'b0, 1'b1, upe_pkg::MODE_SLASH);
        // undefined mode, judged on the item that pushes the byte out
        send_item(upe_pkg::CH_SLASH,   1'b1, 1'b0, upe_pkg::MODE_PLAIN);
        send_item(upe_pkg::CH_PERCENT, 1'b1, 1'b0, MODE_UNDEF);
        send_item(8'h32,               1'b1, 1'b0, MODE_UNDEF);
        send_item(8'h46,               1'b1, 1'b1, MODE_UNDEF);
        // empty strings: only the slash comes out in slash mode
        send_item(8'h00,               1'b0, 1'b1, upe_pkg::MODE_SLASH);
        send_item(8'hFF,               1'b0, 1'b1, upe_pkg::MODE_PLAIN);
        // single byte string in path mode
        send_item(8'h7E,               1'b1, 1'b1, MODE_PATH);
        drain_results();

        target = items_sent + RANDOM_ITEMS;
        random_urls(items_sent + RANDOM_ITEMS / 3);

        // back pressure: keep offering while the receiver holds off
        hold_request <= 1'b1;
        steady_send = 1'b1;
        random_urls(items_sent + 40);
        steady_send = 1'b0;
        drain_results();

        random_urls(target);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
